[src/hsc_pkg.sv]
package hsc_pkg;

    // Field widths
    localparam int unsigned THR_BITS   = 12;
    localparam int unsigned DUTY_BITS  = 13;
    localparam int unsigned STALL_BITS = 24;
    localparam int unsigned STEP_BITS  = 3;
    localparam int unsigned FREQ_BITS  = 12;
    localparam int unsigned TIME_BITS  = 13;
    localparam int unsigned GATE_BITS  = 6;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 24;

    // Default elapsed-time counter width
    localparam int unsigned ELAPSED_BITS_DEF = 32;

    // Serial divider width (numerators and divisors stay below 2^25)
    localparam int unsigned DIV_BITS = 25;
    localparam int unsigned DIV_CNT_BITS = 5;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THROTTLE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THROTTLE_SPAN   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_TIME      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_ADVANCE    = 3'd4;

    // Register reset values
    localparam logic [THR_BITS-1:0]   RST_THROTTLE_OFFSET = 12'd1380;
    localparam logic [THR_BITS-1:0]   RST_THROTTLE_SPAN   = 12'd2808;
    localparam logic [DUTY_BITS-1:0]  RST_DUTY_LIMIT      = 13'd3686;
    localparam logic [STALL_BITS-1:0] RST_STALL_TIME      = 24'd1000000;
    localparam logic [STEP_BITS-1:0]  RST_STEP_ADVANCE    = 3'd2;

    localparam logic [DUTY_BITS-1:0] DUTY_FULL   = 13'd4096;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX    = 12'd4095;
    localparam logic [GATE_BITS-1:0] GATE_ALL_OFF = 6'd63;
    // Beyond this many microseconds the step frequency rounds to zero
    localparam int unsigned ELAPSED_DIV_LIMIT = 8000000;

    // Input and result words
    typedef struct packed {
        logic                hall_u;
        logic                hall_v;
        logic                hall_w;
        logic [THR_BITS-1:0] throttle;
    } t_in_word;

    typedef struct packed {
        logic [GATE_BITS-1:0] gate_pattern;
        logic [TIME_BITS-1:0] on_time_us;
        logic [TIME_BITS-1:0] off_time_us;
        logic [STEP_BITS-1:0] rotor_step;
        logic [FREQ_BITS-1:0] phase_freq;
    } t_out_word;

    // Hall code {u,v,w} to step; bit 3 flags a valid code
    function automatic logic [STEP_BITS:0] hall_decode(input logic [2:0] code);
        logic [STEP_BITS:0] res;
        case (code)
            3'b011:  res = {1'b1, 3'd0};
            3'b010:  res = {1'b1, 3'd1};
            3'b110:  res = {1'b1, 3'd2};
            3'b100:  res = {1'b1, 3'd3};
            3'b101:  res = {1'b1, 3'd4};
            3'b001:  res = {1'b1, 3'd5};
            default: res = {1'b0, 3'd0};
        endcase
        return res;
    endfunction

    // PWM period in us from the held step frequency
    function automatic logic [TIME_BITS-1:0] pwm_period(input logic [FREQ_BITS-1:0] freq);
        logic [TIME_BITS-1:0] per;
        if (freq > 12'd1152)      per = 13'd2500;
        else if (freq > 12'd1008) per = 13'd2857;
        else if (freq > 12'd864)  per = 13'd3205;
        else if (freq > 12'd720)  per = 13'd3401;
        else if (freq > 12'd576)  per = 13'd3816;
        else if (freq > 12'd432)  per = 13'd4273;
        else if (freq > 12'd288)  per = 13'd4484;
        else if (freq > 12'd144)  per = 13'd5076;
        else                      per = 13'd5714;
        return per;
    endfunction

    // Gate word for the sensed step plus advance, taken mod 6
    function automatic logic [GATE_BITS-1:0] drive_pattern(input logic [STEP_BITS-1:0] step,
                                                            input logic [STEP_BITS-1:0] adv);
        logic [3:0]           s;
        logic [GATE_BITS-1:0] g;
        s = 4'(step) + 4'(adv);
        if (s >= 4'd6) s = s - 4'd6;
        if (s >= 4'd6) s = s - 4'd6;
        case (s)
            4'd0:    g = 6'd43;
            4'd1:    g = 6'd51;
            4'd2:    g = 6'd53;
            4'd3:    g = 6'd29;
            4'd4:    g = 6'd30;
            4'd5:    g = 6'd46;
            default: g = GATE_ALL_OFF;
        endcase
        return g;
    endfunction

    // Shortest step distance (0..3) between two steps
    function automatic logic [1:0] step_jump(input logic [STEP_BITS-1:0] new_step,
                                             input logic [STEP_BITS-1:0] old_step);
        logic [3:0] d;
        d = 4'(new_step) + 4'd6 - 4'(old_step);
        if (d >= 4'd6) d = d - 4'd6;
        if (d >= 4'd3) d = 4'd6 - d;
        return d[1:0];
    endfunction

endpackage

[src/hall_six_step_commutator_core.sv]
// Six-step Hall commutator: one word per control period in, one word out. Each word
// is worked through a shared restoring divider that yields one quotient bit per cycle:
// first the throttle-to-duty division, then, only when the Hall step moves to a step
// other than the current and the previous one with elapsed time nonzero and in range,
// the step-frequency division. The input is ready again the cycle after the result is
// registered, so one word is worked at a time. The result may wait in the output
// register while the next word is worked. The configuration port is always ready and
// should be written only while the block is idle.
module hall_six_step_commutator_core
    import hsc_pkg::*;
#(
    parameter int unsigned ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input words
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_word,
    // result words
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_word,
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int unsigned CMP_BITS = (ELAPSED_BITS > STALL_BITS) ? ELAPSED_BITS : STALL_BITS;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_DUTY  = 3'd1;
    localparam logic [2:0] S_DUTY_DONE = 3'd2;
    localparam logic [2:0] S_DIV_FREQ  = 3'd3;
    localparam logic [2:0] S_MUL       = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    // configuration registers
    logic [THR_BITS-1:0]   r_thr_offset;
    logic [THR_BITS-1:0]   r_thr_span;
    logic [DUTY_BITS-1:0]  r_duty_limit;
    logic [STALL_BITS-1:0] r_stall_time;
    logic [STEP_BITS-1:0]  r_step_adv;

    // rotor state
    logic [STEP_BITS-1:0]    r_sensed;
    logic [STEP_BITS-1:0]    r_prev;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [FREQ_BITS-1:0]    r_freq;

    // per-word working registers
    logic [2:0]            r_state;
    logic [STEP_BITS-1:0]  r_new_step;
    logic                  r_valid_code;
    logic                  r_take;
    logic                  r_need_div;
    logic [1:0]            r_jump;
    logic [TIME_BITS-1:0]  r_period;
    logic [DUTY_BITS-1:0]  r_duty;
    logic [TIME_BITS-1:0]  r_on;
    logic [FREQ_BITS-1:0]  r_freq_new;

    // serial divider
    logic [DIV_BITS-1:0]     r_num;
    logic [DIV_BITS-1:0]     r_div;
    logic [DIV_BITS-1:0]     r_rem;
    logic [DIV_BITS-1:0]     r_quo;
    logic [DIV_CNT_BITS-1:0] r_cnt;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    // --- decode of the incoming word against the held state
    logic [STEP_BITS:0]    dec;
    logic                  take;
    logic [CMP_BITS-1:0]   el_x;
    logic                  el_nonzero;
    logic                  el_in_range;
    logic                  el_stalled;
    logic [THR_BITS-1:0]   thr_diff;
    logic [DIV_BITS-1:0]   duty_num;
    logic [DIV_BITS-1:0]   duty_den;

    assign dec         = hall_decode({i_in_word.hall_u, i_in_word.hall_v, i_in_word.hall_w});
    assign take        = dec[STEP_BITS] && (dec[STEP_BITS-1:0] != r_sensed)
                         && (dec[STEP_BITS-1:0] != r_prev);
    assign el_x        = CMP_BITS'(r_elapsed);
    assign el_nonzero  = (r_elapsed != '0);
    assign el_in_range = (el_x <= CMP_BITS'(ELAPSED_DIV_LIMIT));
    assign el_stalled  = (el_x > CMP_BITS'(r_stall_time));
    assign thr_diff    = i_in_word.throttle - r_thr_offset;
    assign duty_num    = (i_in_word.throttle > r_thr_offset) ?
                         {1'b0, thr_diff, 12'd0} : '0;
    assign duty_den    = (r_thr_span == '0) ? DIV_BITS'(1) : DIV_BITS'(r_thr_span);

    // --- frequency division operands
    logic [22:0]         el23;
    logic [DIV_BITS-1:0] freq_den;
    logic [DIV_BITS-1:0] freq_num;

    assign el23     = el_x[22:0];
    assign freq_den = DIV_BITS'(el23) + DIV_BITS'({el23, 1'b0});
    always_comb begin
        case (r_jump)
            2'd1:    freq_num = DIV_BITS'(8000000);
            2'd2:    freq_num = DIV_BITS'(16000000);
            2'd3:    freq_num = DIV_BITS'(24000000);
            default: freq_num = '0;
        endcase
    end

    // --- one restoring division step
    logic [DIV_BITS:0]   rem_sh;
    logic [DIV_BITS+1:0] rem_diff;
    logic                q_bit;
    logic [DIV_BITS-1:0] n_rem;
    logic                div_last;

    assign rem_sh   = {r_rem, r_num[DIV_BITS-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_div};
    assign q_bit    = !rem_diff[DIV_BITS+1];
    assign n_rem    = q_bit ? rem_diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
    assign div_last = (r_cnt == DIV_CNT_BITS'(DIV_BITS - 1));

    // --- duty clamp
    logic [DUTY_BITS-1:0] lim;
    logic [DUTY_BITS-1:0] n_duty;

    assign lim    = (r_duty_limit > DUTY_FULL) ? DUTY_FULL : r_duty_limit;
    assign n_duty = (r_quo > DIV_BITS'(lim)) ? lim : r_quo[DUTY_BITS-1:0];

    // --- on time and new frequency
    logic [2*TIME_BITS-1:0] prod;
    logic [FREQ_BITS-1:0]   n_freq;

    assign prod = r_period * r_duty;
    always_comb begin
        n_freq = r_freq;
        if (r_valid_code && r_take) begin
            if (!el_nonzero) begin
                n_freq = r_freq;
            end else if (!el_in_range) begin
                n_freq = '0;
            end else if (r_quo > DIV_BITS'(FREQ_MAX)) begin
                n_freq = FREQ_MAX;
            end else begin
                n_freq = r_quo[FREQ_BITS-1:0];
            end
        end else if (r_valid_code && el_stalled) begin
            n_freq = '0;
        end
    end

    // --- commit values
    logic [STEP_BITS-1:0]  n_sensed;
    logic [ELAPSED_BITS:0] el_sum;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic                  out_free;

    assign n_sensed  = r_take ? r_new_step : r_sensed;
    assign el_sum    = {1'b0, (r_take ? {ELAPSED_BITS{1'b0}} : r_elapsed)}
                       + (ELAPSED_BITS+1)'(r_period);
    assign n_elapsed = el_sum[ELAPSED_BITS] ? '1 : el_sum[ELAPSED_BITS-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_offset <= RST_THROTTLE_OFFSET;
            r_thr_span   <= RST_THROTTLE_SPAN;
            r_duty_limit <= RST_DUTY_LIMIT;
            r_stall_time <= RST_STALL_TIME;
            r_step_adv   <= RST_STEP_ADVANCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THROTTLE_OFFSET: r_thr_offset <= i_cfg_data[THR_BITS-1:0];
                CFG_THROTTLE_SPAN:   r_thr_span   <= i_cfg_data[THR_BITS-1:0];
                CFG_DUTY_LIMIT:      r_duty_limit <= i_cfg_data[DUTY_BITS-1:0];
                CFG_STALL_TIME:      r_stall_time <= i_cfg_data[STALL_BITS-1:0];
                CFG_STEP_ADVANCE:    r_step_adv   <= i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and rotor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sensed    <= '0;
            r_prev      <= '0;
            r_elapsed   <= '0;
            r_freq      <= '0;
        end else begin
            // result flag: set as a word completes, cleared once taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DIV_DUTY;
                    end
                end
                S_DIV_DUTY: begin
                    if (div_last) begin
                        r_state <= S_DUTY_DONE;
                    end
                end
                S_DUTY_DONE: begin
                    r_state <= r_need_div ? S_DIV_FREQ : S_MUL;
                end
                S_DIV_FREQ: begin
                    if (div_last) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_sensed    <= n_sensed;
                        r_prev      <= r_take ? r_sensed : r_prev;
                        r_elapsed   <= n_elapsed;
                        r_freq      <= r_freq_new;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers and divider datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_new_step   <= dec[STEP_BITS-1:0];
                r_valid_code <= dec[STEP_BITS];
                r_take       <= take;
                r_need_div   <= take && el_nonzero && el_in_range;
                r_jump       <= step_jump(dec[STEP_BITS-1:0], r_sensed);
                r_period     <= pwm_period(r_freq);
                r_num        <= duty_num;
                r_div        <= duty_den;
                r_rem        <= '0;
                r_quo        <= '0;
                r_cnt        <= '0;
            end
            S_DIV_DUTY, S_DIV_FREQ: begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIV_BITS-2:0], q_bit};
                r_num <= {r_num[DIV_BITS-2:0], 1'b0};
                r_cnt <= r_cnt + DIV_CNT_BITS'(1);
            end
            S_DUTY_DONE: begin
                r_duty <= n_duty;
                r_num  <= freq_num;
                r_div  <= freq_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            S_MUL: begin
                r_on       <= prod[TIME_BITS+11:12];
                r_freq_new <= n_freq;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_word.gate_pattern <= (r_on != '0) ?
                                               drive_pattern(n_sensed, r_step_adv) : GATE_ALL_OFF;
                    r_out_word.on_time_us   <= r_on;
                    r_out_word.off_time_us  <= r_period - r_on;
                    r_out_word.rotor_step   <= n_sensed;
                    r_out_word.phase_freq   <= r_freq_new;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

endmodule

[src/hsc_checker.sv]
module hsc_checker
    import hsc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a result word held back by the sink stays put
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // one word at a time: no new word straight after acceptance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // zero on time means all gates off
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.on_time_us == '0) |-> (o_out_word.gate_pattern == GATE_ALL_OFF))
        else $error("gates driven with zero on time");

    // on plus off is always one of the table periods
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd5714 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd5076 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd4484 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd4273 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd3816 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd3401 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd3205 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd2857 ||
             (14'(o_out_word.on_time_us) + 14'(o_out_word.off_time_us)) == 14'd2500))
        else $error("on and off times do not add up to a PWM period");

    // sensed step stays within the six positions
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.rotor_step <= 3'd5))
        else $error("rotor step out of range");

endmodule

bind hall_six_step_commutator_core hsc_checker u_hsc_checker (.*);
